[hdl/exponential_adsr_envelope_unit_defines.svh]
// ----------------------------------------------------------------------------
// Envelope unit assertion macros
// Clocked, reset-qualified property wrappers used by the envelope unit.
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_ADSR_ENVELOPE_UNIT_DEFINES_SVH
`define EXPONENTIAL_ADSR_ENVELOPE_UNIT_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define EADSR_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a condition leads to another in the next cycle.
`define EADSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/eadsr_pkg.sv]
// ----------------------------------------------------------------------------
// Envelope unit package
// Widths, codes and fixed-point constants shared by the envelope unit.
// ----------------------------------------------------------------------------
`default_nettype none

package eadsr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 24;
    localparam int LEVEL_BITS  = FRAC_BITS + 1;
    localparam int COEFF_BITS  = FRAC_BITS;
    localparam int ABASE_BITS  = FRAC_BITS + 1;
    localparam int DBASE_BITS  = FRAC_BITS + 2;
    localparam int RBASE_BITS  = 12;
    localparam int SUM_BITS    = LEVEL_BITS + 2;
    localparam int PROD_BITS   = 2 * LEVEL_BITS;
    localparam int MAG_BITS    = SAMPLE_BITS;

    localparam int DATA_BITS    = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int ADDR_BITS    = CFG_IDX_BITS + 2;

    // Request codes
    localparam logic [1:0] REQ_SAMPLE   = 2'd0;
    localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd2;
    localparam logic [1:0] REQ_RESET    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK_COEFF  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK_BASE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_COEFF   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_BASE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN_LEVEL = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_COEFF = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_BASE  = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL1 = 5'b00010,
        ST_ADD  = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(64'd1 << FRAC_BITS);
    localparam logic signed [SUM_BITS-1:0] SUM_ONE = SUM_BITS'(64'd1 << FRAC_BITS);
    localparam logic signed [SUM_BITS-1:0] SUM_LEVEL_MAX =
        SUM_BITS'((64'd1 << LEVEL_BITS) - 64'd1);

    // Output clamp limits on the magnitude
    localparam logic [LEVEL_BITS-1:0] MAG_POS_LIM =
        LEVEL_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [LEVEL_BITS-1:0] MAG_NEG_LIM =
        LEVEL_BITS'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX =
        SAMPLE_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN =
        SAMPLE_BITS'(64'd1 << (SAMPLE_BITS - 1));

endpackage

`default_nettype wire

[hdl/exponential_adsr_envelope_unit.sv]
// ----------------------------------------------------------------------------
// Exponential ADSR envelope unit
// Advances a five-phase exponential envelope per audio sample and scales
// the sample by it, using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries requests: audio sample, note
//   on, note off and voice reset. Only an audio sample yields a result beat
//   on the output channel (o_valid / i_stall).
//   Note on, note off and voice reset are handled while the sequencer stays idle.
//   An audio sample is worked in order by the sequencer steps: one
//   multiply for the envelope step, one add and clamp, one multiply for the
//   sample scaling, and a last step to load the output register. No new
//   request is accepted until the sample is through. The single 25x25
//   multiplier is used twice per sample.
//   While the output register holds an untaken beat, the unit still accepts
//   and works a new sample, then waits in its last step until the beat is
//   taken. o_stall is high whenever the sequencer is busy.
//   Reset sets the phase to idle, clears the level and the configuration
//   registers to zero and drops the output beat. The user must write the
//   registers over the APB port only while the unit is idle (not enforced).
`default_nettype none

`include "exponential_adsr_envelope_unit_defines.svh"

module exponential_adsr_envelope_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // request channel
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [1:0]                            i_req_type,
    input  wire logic signed [eadsr_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic                                  i_block_last,
    // result channel
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [eadsr_pkg::SAMPLE_BITS-1:0]   o_sample_out,
    output logic [eadsr_pkg::LEVEL_BITS-1:0]           o_envelope_level,
    output logic                                       o_voice_active,
    output logic                                       o_block_end,
    // configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [eadsr_pkg::ADDR_BITS-1:0]       paddr,
    input  wire logic [eadsr_pkg::DATA_BITS-1:0]       pwdata,
    output logic [eadsr_pkg::DATA_BITS-1:0]            prdata,
    output logic                                       pready
);

    localparam int LB = eadsr_pkg::LEVEL_BITS;
    localparam int FB = eadsr_pkg::FRAC_BITS;
    localparam int SB = eadsr_pkg::SUM_BITS;
    localparam int DW = eadsr_pkg::DATA_BITS;
    localparam int ADDR_BITS_HI = eadsr_pkg::ADDR_BITS - 1;

    // configuration registers
    logic [eadsr_pkg::COEFF_BITS-1:0]        r_attack_coeff;
    logic [eadsr_pkg::ABASE_BITS-1:0]        r_attack_base;
    logic [eadsr_pkg::COEFF_BITS-1:0]        r_decay_coeff;
    logic signed [eadsr_pkg::DBASE_BITS-1:0] r_decay_base;
    logic [LB-1:0]                           r_sustain_level;
    logic [eadsr_pkg::COEFF_BITS-1:0]        r_release_coeff;
    logic signed [eadsr_pkg::RBASE_BITS-1:0] r_release_base;

    // envelope and sequencer state
    eadsr_pkg::t_state r_state, n_state;
    eadsr_pkg::t_phase r_phase, n_phase;
    logic [LB-1:0]     r_level, n_level;

    // per-sample working registers
    logic [eadsr_pkg::MAG_BITS-1:0]  r_mag;
    logic                            r_neg;
    logic                            r_last;
    logic [eadsr_pkg::PROD_BITS-1:0] r_prod;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [eadsr_pkg::SAMPLE_BITS-1:0] r_out_sample;
    logic [LB-1:0]                   r_out_level;
    logic                            r_out_active;
    logic                            r_out_last;

    logic                                in_accept;
    logic                                cfg_write;
    logic [eadsr_pkg::CFG_IDX_BITS-1:0]  cfg_idx;
    logic [LB-1:0]                       mul_a;
    logic [LB-1:0]                       mul_b;
    logic [eadsr_pkg::PROD_BITS-1:0]     prod;
    logic [LB-1:0]                       scaled;
    logic signed [SB-1:0]                step_base;
    logic signed [SB-1:0]                step_sum;
    logic [eadsr_pkg::COEFF_BITS-1:0]    coeff_sel;
    logic [eadsr_pkg::SAMPLE_BITS-1:0]   mag_lo;
    logic [eadsr_pkg::SAMPLE_BITS-1:0]   out_sample;
    logic                                out_free;

    assign in_accept = i_valid && !o_stall;
    assign o_stall   = (r_state != eadsr_pkg::ST_IDLE);
    assign out_free  = !r_out_valid || !i_stall;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[ADDR_BITS_HI:2];
    assign pready    = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_coeff  <= '0;
            r_attack_base   <= '0;
            r_decay_coeff   <= '0;
            r_decay_base    <= '0;
            r_sustain_level <= '0;
            r_release_coeff <= '0;
            r_release_base  <= '0;
        end else if (cfg_write) begin
            case (cfg_idx)
                eadsr_pkg::REG_ATTACK_COEFF:  r_attack_coeff  <= pwdata[eadsr_pkg::COEFF_BITS-1:0];
                eadsr_pkg::REG_ATTACK_BASE:   r_attack_base   <= pwdata[eadsr_pkg::ABASE_BITS-1:0];
                eadsr_pkg::REG_DECAY_COEFF:   r_decay_coeff   <= pwdata[eadsr_pkg::COEFF_BITS-1:0];
                eadsr_pkg::REG_DECAY_BASE:    r_decay_base    <= pwdata[eadsr_pkg::DBASE_BITS-1:0];
                eadsr_pkg::REG_SUSTAIN_LEVEL: r_sustain_level <= pwdata[LB-1:0];
                eadsr_pkg::REG_RELEASE_COEFF: r_release_coeff <= pwdata[eadsr_pkg::COEFF_BITS-1:0];
                eadsr_pkg::REG_RELEASE_BASE:  r_release_base  <= pwdata[eadsr_pkg::RBASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            eadsr_pkg::REG_ATTACK_COEFF:  prdata = DW'(r_attack_coeff);
            eadsr_pkg::REG_ATTACK_BASE:   prdata = DW'(r_attack_base);
            eadsr_pkg::REG_DECAY_COEFF:   prdata = DW'(r_decay_coeff);
            eadsr_pkg::REG_DECAY_BASE:    prdata = DW'(r_decay_base);
            eadsr_pkg::REG_SUSTAIN_LEVEL: prdata = DW'(r_sustain_level);
            eadsr_pkg::REG_RELEASE_COEFF: prdata = DW'(r_release_coeff);
            eadsr_pkg::REG_RELEASE_BASE:  prdata = DW'(r_release_base);
            default:                      prdata = '0;
        endcase
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        case (r_phase)
            eadsr_pkg::PH_ATTACK:  coeff_sel = r_attack_coeff;
            eadsr_pkg::PH_DECAY:   coeff_sel = r_decay_coeff;
            eadsr_pkg::PH_RELEASE: coeff_sel = r_release_coeff;
            default:               coeff_sel = '0;
        endcase
    end

    // envelope step uses the coefficient, sample scaling the magnitude
    assign mul_a  = r_level;
    assign mul_b  = (r_state == eadsr_pkg::ST_MUL2) ? LB'(r_mag) : LB'(coeff_sel);
    assign prod   = eadsr_pkg::PROD_BITS'(mul_a) * eadsr_pkg::PROD_BITS'(mul_b);
    assign scaled = r_prod[FB+LB-1:FB];

    // ---------------- envelope step ----------------
    always_comb begin
        case (r_phase)
            eadsr_pkg::PH_ATTACK:  step_base = $signed(SB'(r_attack_base));
            eadsr_pkg::PH_DECAY:   step_base = SB'(r_decay_base);
            eadsr_pkg::PH_RELEASE: step_base = SB'(r_release_base);
            default:               step_base = '0;
        endcase
    end

    assign step_sum = $signed(SB'(scaled)) + step_base;

    // ---------------- output clamp ----------------
    assign mag_lo = scaled[eadsr_pkg::SAMPLE_BITS-1:0];

    always_comb begin
        if (r_neg) begin
            out_sample = (scaled > eadsr_pkg::MAG_NEG_LIM) ? eadsr_pkg::SAMPLE_MIN
                                                           : (~mag_lo + 1'b1);
        end else begin
            out_sample = (scaled > eadsr_pkg::MAG_POS_LIM) ? eadsr_pkg::SAMPLE_MAX : mag_lo;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_level     = r_level;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            eadsr_pkg::ST_IDLE: begin
                if (in_accept) begin
                    case (i_req_type)
                        eadsr_pkg::REQ_SAMPLE: n_state = eadsr_pkg::ST_MUL1;
                        eadsr_pkg::REQ_NOTE_ON: begin
                            if (r_phase inside {eadsr_pkg::PH_IDLE, eadsr_pkg::PH_RELEASE}) begin
                                n_phase = eadsr_pkg::PH_ATTACK;
                            end
                        end
                        eadsr_pkg::REQ_NOTE_OFF: begin
                            if (r_phase != eadsr_pkg::PH_IDLE) begin
                                n_phase = eadsr_pkg::PH_RELEASE;
                            end
                        end
                        default: begin
                            n_phase = eadsr_pkg::PH_IDLE;
                            n_level = '0;
                        end
                    endcase
                end
            end
            eadsr_pkg::ST_MUL1: n_state = eadsr_pkg::ST_ADD;
            eadsr_pkg::ST_ADD: begin
                n_state = eadsr_pkg::ST_MUL2;
                case (r_phase)
                    eadsr_pkg::PH_ATTACK: begin
                        if (step_sum >= eadsr_pkg::SUM_ONE) begin
                            n_level = eadsr_pkg::LEVEL_ONE;
                            n_phase = eadsr_pkg::PH_DECAY;
                        end else begin
                            n_level = step_sum[LB-1:0];
                        end
                    end
                    eadsr_pkg::PH_DECAY: begin
                        if (step_sum <= $signed(SB'(r_sustain_level))) begin
                            n_level = r_sustain_level;
                            n_phase = eadsr_pkg::PH_SUSTAIN;
                        end else if (step_sum > eadsr_pkg::SUM_LEVEL_MAX) begin
                            n_level = '1;
                        end else begin
                            n_level = step_sum[LB-1:0];
                        end
                    end
                    eadsr_pkg::PH_RELEASE: begin
                        if (step_sum <= $signed(SB'(0))) begin
                            n_level = '0;
                            n_phase = eadsr_pkg::PH_IDLE;
                        end else if (step_sum > eadsr_pkg::SUM_LEVEL_MAX) begin
                            n_level = '1;
                        end else begin
                            n_level = step_sum[LB-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            eadsr_pkg::ST_MUL2: n_state = eadsr_pkg::ST_FIN;
            eadsr_pkg::ST_FIN: begin
                // hold until the output register can take the beat
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = eadsr_pkg::ST_IDLE;
                end
            end
            default: n_state = eadsr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= eadsr_pkg::ST_IDLE;
            r_phase     <= eadsr_pkg::PH_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mag  <= i_sample_in[eadsr_pkg::SAMPLE_BITS-1] ? (~i_sample_in + 1'b1)
                                                            : i_sample_in;
            r_neg  <= i_sample_in[eadsr_pkg::SAMPLE_BITS-1];
            r_last <= i_block_last;
        end
        if (r_state == eadsr_pkg::ST_MUL1 || r_state == eadsr_pkg::ST_MUL2) begin
            r_prod <= prod;
        end
        if (r_state == eadsr_pkg::ST_FIN && out_free) begin
            r_out_sample <= out_sample;
            r_out_level  <= r_level;
            r_out_active <= (r_phase != eadsr_pkg::PH_IDLE);
            r_out_last   <= r_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_sample_out     = r_out_sample;
    assign o_envelope_level = r_out_level;
    assign o_voice_active   = r_out_active;
    assign o_block_end      = r_out_last;

    // ---------------- assertions ----------------
    `EADSR_ASSERT_NOW(a_idle_level_zero,
        (r_phase != eadsr_pkg::PH_IDLE) || (r_level == '0),
        "idle phase with nonzero level")
    `EADSR_ASSERT_NEXT(a_sample_starts,
        (in_accept && i_req_type == eadsr_pkg::REQ_SAMPLE),
        (r_state == eadsr_pkg::ST_MUL1),
        "accepted sample did not start the sequencer")
    `EADSR_ASSERT_NEXT(a_fin_delivers,
        (r_state == eadsr_pkg::ST_FIN && out_free),
        (r_out_valid && r_state == eadsr_pkg::ST_IDLE),
        "finished sample not loaded into the output register")

endmodule

`default_nettype wire
